// ===== sv/vtu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_pkg: shared types and constants for the 2-D point transform unit
// Item layouts, command codes, CORDIC tables and the saturation helper.
// ----------------------------------------------------------------------------
package vtu_pkg;

    // Command codes
    localparam logic [2:0] CMD_ROTATE    = 3'd0;
    localparam logic [2:0] CMD_SCALE     = 3'd1;
    localparam logic [2:0] CMD_TRANSLATE = 3'd2;
    localparam logic [2:0] CMD_NORMALIZE = 3'd3;
    localparam logic [2:0] CMD_LENGTH    = 3'd4;

    // CORDIC start gain and degree-to-radian factor (Q2.30 / Q37)
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] DEG_TO_RAD_Q37  = 32'd2398762259;

    // Saturation bounds
    localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] param_a;
        logic signed [31:0] param_b;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [31:0]        length;
        logic               zero_length;
        logic               saturated;
    } res_item_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } sat_t;

    // Clip a wide signed value to 32 bits signed
    function automatic sat_t sat32(input logic signed [66:0] v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.val  = 32'sh7FFFFFFF;
            r.clip = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val  = 32'sh80000000;
            r.clip = 1'b1;
        end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Arctangent of 2^-idx in Q2.30
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'd843314857;
            1:  a = 32'd497837829;
            2:  a = 32'd263043837;
            3:  a = 32'd133525159;
            4:  a = 32'd67021687;
            5:  a = 32'd33543516;
            6:  a = 32'd16775851;
            7:  a = 32'd8388437;
            8:  a = 32'd4194283;
            9:  a = 32'd2097149;
            10: a = 32'd1048576;
            11: a = 32'd524288;
            12: a = 32'd262144;
            13: a = 32'd131072;
            14: a = 32'd65536;
            15: a = 32'd32768;
            16: a = 32'd16384;
            17: a = 32'd8192;
            18: a = 32'd4096;
            19: a = 32'd2048;
            20: a = 32'd1024;
            21: a = 32'd512;
            22: a = 32'd256;
            23: a = 32'd128;
            24: a = 32'd64;
            25: a = 32'd32;
            26: a = 32'd16;
            27: a = 32'd8;
            28: a = 32'd4;
            29: a = 32'd2;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vtu_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_delay: enabled shift line
// Keeps side data aligned with the cell chains; depth zero is a plain wire.
// ----------------------------------------------------------------------------
module vtu_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_pass
            assign dout = din;
        end else begin : g_line
            logic [WIDTH-1:0] dly_reg [DEPTH];

            // shift on every advancing cycle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[0] <= din;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        dly_reg[i] <= dly_reg[i-1];
                    end
                end
            end

            assign dout = dly_reg[DEPTH-1];
        end
    endgenerate

endmodule
`default_nettype wire

// ===== sv/vtu_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_sqrt_cell: one digit of the integer square root
// Tests one result bit against the remaining radicand and hands both on.
// ----------------------------------------------------------------------------
module vtu_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] num_in,
    input  wire logic [63:0] root_in,
    output logic      [63:0] num_out,
    output logic      [63:0] root_out
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic [63:0] num_reg;
    logic [63:0] root_reg;

    assign trial = root_in + BIT;

    // restoring root step
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (num_in >= trial)
            begin
                num_reg  <= num_in - trial;
                root_reg <= (root_in >> 1) + BIT;
            end else begin
                num_reg  <= num_in;
                root_reg <= root_in >> 1;
            end
        end
    end

    assign num_out  = num_reg;
    assign root_out = root_reg;

endmodule
`default_nettype wire

// ===== sv/vtu_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_div_cell: one quotient bit of the normalize divide, both axes
// Compares the partial remainders against the length and passes all on.
// ----------------------------------------------------------------------------
module vtu_div_cell #(
    parameter int QW = 17
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [31:0]   den_in,
    input  wire logic [32:0]   rx_in,
    input  wire logic [32:0]   ry_in,
    input  wire logic [QW-1:0] qx_in,
    input  wire logic [QW-1:0] qy_in,
    output logic      [31:0]   den_out,
    output logic      [32:0]   rx_out,
    output logic      [32:0]   ry_out,
    output logic      [QW-1:0] qx_out,
    output logic      [QW-1:0] qy_out
);

    logic        gex;
    logic        gey;
    logic [32:0] subx;
    logic [32:0] suby;

    logic [31:0]   den_reg;
    logic [32:0]   rx_reg;
    logic [32:0]   ry_reg;
    logic [QW-1:0] qx_reg;
    logic [QW-1:0] qy_reg;

    // trial subtract; remainder stays below the length
    always_comb
    begin
        gex  = rx_in >= {1'b0, den_in};
        gey  = ry_in >= {1'b0, den_in};
        subx = gex ? (rx_in - {1'b0, den_in}) : rx_in;
        suby = gey ? (ry_in - {1'b0, den_in}) : ry_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rx_reg  <= {subx[31:0], 1'b0};
            ry_reg  <= {suby[31:0], 1'b0};
            qx_reg  <= {qx_in[QW-2:0], gex};
            qy_reg  <= {qy_in[QW-2:0], gey};
        end
    end

    assign den_out = den_reg;
    assign rx_out  = rx_reg;
    assign ry_out  = ry_reg;
    assign qx_out  = qx_reg;
    assign qy_out  = qy_reg;

endmodule
`default_nettype wire

// ===== sv/vtu_red_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_red_cell: one step of the angle modulo reduction
// Takes a fixed multiple of a full turn off the angle magnitude if it fits.
// ----------------------------------------------------------------------------
module vtu_red_cell #(
    parameter logic [33:0] SUB = 34'd23592960
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] mag_in,
    output logic      [31:0] mag_out
);

    logic [31:0] mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if ({2'b00, mag_in} >= SUB)
            begin
                mag_reg <= mag_in - SUB[31:0];
            end else begin
                mag_reg <= mag_in;
            end
        end
    end

    assign mag_out = mag_reg;

endmodule
`default_nettype wire

// ===== sv/vtu_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtu_cordic_cell: one rotation-mode CORDIC micro-rotation
// Turns the vector by the fixed arctangent of its stage toward zero angle.
// ----------------------------------------------------------------------------
module vtu_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [33:0] cx_in,
    input  wire logic signed [33:0] cy_in,
    input  wire logic signed [33:0] z_in,
    output logic signed      [33:0] cx_out,
    output logic signed      [33:0] cy_out,
    output logic signed      [33:0] z_out
);

    localparam logic signed [33:0] ATAN = $signed({2'b00, vtu_pkg::atan_q30(IDX)});

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] z_reg;

    assign dx = cy_in >>> IDX;
    assign dy = cx_in >>> IDX;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_in >= 0)
            begin
                cx_reg <= cx_in - dx;
                cy_reg <= cy_in + dy;
                z_reg  <= z_in - ATAN;
            end else begin
                cx_reg <= cx_in + dx;
                cy_reg <= cy_in - dy;
                z_reg  <= z_in + ATAN;
            end
        end
    end

    assign cx_out = cx_reg;
    assign cy_out = cy_reg;
    assign z_out  = z_reg;

endmodule
`default_nettype wire

// ===== sv/vec2_transform_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vec2_transform_unit_top: 2-D point transform (rotate/scale/translate/
// normalize/length) on signed fixed-point points
// Fully pipelined; one item per clock unless stalled; nothing kept between items.
// ----------------------------------------------------------------------------
// The unit accepts one item every clock while no result is held. The longest
// path is normally the length/normalize chain: 32 square-root cells followed
// by FRAC_BITS + 1 divide cells; the rotate chain is the angle-reduction cells
// followed by one CORDIC cell per stage. The whole pipe advances together, so
// a held result holds every item behind it and the input sees stall while
// res_stall holds a valid result.
module vec2_transform_unit_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire vtu_pkg::cmd_item_t  cmd_item,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output vtu_pkg::res_item_t       res_item
);

    localparam int NC     = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int RED    = (FRAC_BITS < 23) ? (23 - FRAC_BITS) : 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int LEN_P  = FRAC_BITS + 36;
    localparam int LEN_R  = RED + NC + 6;
    localparam int LEN_S  = 2;
    localparam int L      = (LEN_P > LEN_R) ? LEN_P : LEN_R;

    localparam logic signed [34:0] FULL_S    = 35'(64'sd360 <<< FRAC_BITS);
    localparam logic signed [34:0] HALF_S    = 35'(64'sd180 <<< FRAC_BITS);
    localparam logic signed [34:0] QUARTER_S = 35'(64'sd90 <<< FRAC_BITS);

    logic en;
    logic [L:0] vld_reg;

    // pipe advances unless a finished item is held
    assign en        = !(res_valid && res_stall);
    assign cmd_stall = res_valid && res_stall;
    assign res_valid = vld_reg[L];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-1:0], cmd_valid};
        end
    end

    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] a_in;
    logic signed [31:0] b_in;

    assign x_in = cmd_item.in_x;
    assign y_in = cmd_item.in_y;
    assign a_in = cmd_item.param_a;
    assign b_in = cmd_item.param_b;

    // ------------------------------------------------------------------
    // Length and normalize chain
    // ------------------------------------------------------------------
    logic signed [63:0] xe64;
    logic signed [63:0] ye64;
    logic [63:0] sqx_reg;
    logic [63:0] sqy_reg;
    logic [63:0] sumsq_reg;

    assign xe64 = 64'(x_in);
    assign ye64 = 64'(y_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg   <= xe64 * xe64;
            sqy_reg   <= ye64 * ye64;
            sumsq_reg <= sqx_reg + sqy_reg;
        end
    end

    logic [63:0] sq_num  [0:32];
    logic [63:0] sq_root [0:32];

    assign sq_num[0]  = sumsq_reg;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        vtu_sqrt_cell #(.STEP(k)) u_cell (
            .clk      (clk),
            .en       (en),
            .num_in   (sq_num[k]),
            .root_in  (sq_root[k]),
            .num_out  (sq_num[k+1]),
            .root_out (sq_root[k+1])
        );
    end

    // point aligned with the root
    logic [63:0] pxy_dly;
    vtu_delay #(.WIDTH(64), .DEPTH(34)) u_pxy_dly (
        .clk  (clk),
        .en   (en),
        .din  ({x_in, y_in}),
        .dout (pxy_dly)
    );

    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0] magx;
    logic [31:0] magy;

    assign px   = pxy_dly[63:32];
    assign py   = pxy_dly[31:0];
    assign magx = px[31] ? (32'd0 - px) : px;
    assign magy = py[31] ? (32'd0 - py) : py;

    logic [31:0]   dv_den [0:QW];
    logic [32:0]   dv_rx  [0:QW];
    logic [32:0]   dv_ry  [0:QW];
    logic [QW-1:0] dv_qx  [0:QW];
    logic [QW-1:0] dv_qy  [0:QW];

    assign dv_den[0] = sq_root[32][31:0];
    assign dv_rx[0]  = {1'b0, magx};
    assign dv_ry[0]  = {1'b0, magy};
    assign dv_qx[0]  = '0;
    assign dv_qy[0]  = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        vtu_div_cell #(.QW(QW)) u_cell (
            .clk     (clk),
            .en      (en),
            .den_in  (dv_den[k]),
            .rx_in   (dv_rx[k]),
            .ry_in   (dv_ry[k]),
            .qx_in   (dv_qx[k]),
            .qy_in   (dv_qy[k]),
            .den_out (dv_den[k+1]),
            .rx_out  (dv_rx[k+1]),
            .ry_out  (dv_ry[k+1]),
            .qx_out  (dv_qx[k+1]),
            .qy_out  (dv_qy[k+1])
        );
    end

    logic [1:0] psgn_dly;
    vtu_delay #(.WIDTH(2), .DEPTH(QW)) u_psgn_dly (
        .clk  (clk),
        .en   (en),
        .din  ({px[31], py[31]}),
        .dout (psgn_dly)
    );

    logic [31:0]        len_reg;
    logic signed [31:0] nx_reg;
    logic signed [31:0] ny_reg;
    logic [31:0]        qx32;
    logic [31:0]        qy32;

    assign qx32 = 32'(dv_qx[QW]);
    assign qy32 = 32'(dv_qy[QW]);

    // restore the signs of the quotients
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= dv_den[QW];
            nx_reg  <= psgn_dly[1] ? (32'd0 - qx32) : qx32;
            ny_reg  <= psgn_dly[0] ? (32'd0 - qy32) : qy32;
        end
    end

    logic [95:0] p_out;
    vtu_delay #(.WIDTH(96), .DEPTH(L - LEN_P)) u_p_dly (
        .clk  (clk),
        .en   (en),
        .din  ({len_reg, nx_reg, ny_reg}),
        .dout (p_out)
    );

    // ------------------------------------------------------------------
    // Rotate chain: angle reduction, radians, CORDIC, final products
    // ------------------------------------------------------------------
    logic [31:0] rd_mag [0:RED];

    assign rd_mag[0] = a_in[31] ? (32'd0 - a_in) : a_in;

    for (genvar k = 0; k < RED; k++) begin : g_red
        vtu_red_cell #(.SUB(34'(64'd360 << (FRAC_BITS + RED - 1 - k)))) u_cell (
            .clk     (clk),
            .en      (en),
            .mag_in  (rd_mag[k]),
            .mag_out (rd_mag[k+1])
        );
    end

    logic asgn_dly;
    vtu_delay #(.WIDTH(1), .DEPTH(RED)) u_asgn_dly (
        .clk  (clk),
        .en   (en),
        .din  (a_in[31]),
        .dout (asgn_dly)
    );

    logic signed [34:0] r0;
    logic signed [34:0] r1;
    logic signed [34:0] r2;
    logic signed [34:0] r3;
    logic               flip_next;
    logic signed [31:0] ang_reg;
    logic               flip_reg;

    // fold the angle into [-90, 90] degrees
    always_comb
    begin
        r0 = asgn_dly ? (35'sd0 - $signed({3'b000, rd_mag[RED]}))
                      : $signed({3'b000, rd_mag[RED]});
        r1 = (r0 < 0) ? (r0 + FULL_S) : r0;
        r2 = (r1 > HALF_S) ? (r1 - FULL_S) : r1;
        flip_next = 1'b0;
        r3 = r2;
        if (r2 > QUARTER_S)
        begin
            r3 = r2 - HALF_S;
            flip_next = 1'b1;
        end else if (r2 < -QUARTER_S) begin
            r3 = r2 + HALF_S;
            flip_next = 1'b1;
        end
    end

    logic signed [64:0] ang_ext;
    logic signed [64:0] deg_ext;
    logic signed [64:0] zprod_reg;
    logic signed [64:0] zrnd;
    logic signed [33:0] z0_reg;

    assign ang_ext = 65'(ang_reg);
    assign deg_ext = $signed({33'd0, vtu_pkg::DEG_TO_RAD_Q37});
    assign zrnd    = (zprod_reg + (65'sd1 <<< (FRAC_BITS + 6))) >>> (FRAC_BITS + 7);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg   <= r3[31:0];
            flip_reg  <= flip_next;
            zprod_reg <= ang_ext * deg_ext;
            z0_reg    <= zrnd[33:0];
        end
    end

    logic signed [33:0] cd_cx [0:NC];
    logic signed [33:0] cd_cy [0:NC];
    logic signed [33:0] cd_z  [0:NC];

    assign cd_cx[0] = $signed({2'b00, vtu_pkg::CORDIC_GAIN_Q30});
    assign cd_cy[0] = '0;
    assign cd_z[0]  = z0_reg;

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        vtu_cordic_cell #(.IDX(k)) u_cell (
            .clk    (clk),
            .en     (en),
            .cx_in  (cd_cx[k]),
            .cy_in  (cd_cy[k]),
            .z_in   (cd_z[k]),
            .cx_out (cd_cx[k+1]),
            .cy_out (cd_cy[k+1]),
            .z_out  (cd_z[k+1])
        );
    end

    logic flip_dly;
    vtu_delay #(.WIDTH(1), .DEPTH(NC + 2)) u_flip_dly (
        .clk  (clk),
        .en   (en),
        .din  (flip_reg),
        .dout (flip_dly)
    );

    logic [63:0] rxy_dly;
    vtu_delay #(.WIDTH(64), .DEPTH(RED + NC + 3)) u_rxy_dly (
        .clk  (clk),
        .en   (en),
        .din  ({x_in, y_in}),
        .dout (rxy_dly)
    );

    logic signed [33:0] cxf;
    logic signed [33:0] cyf;
    logic signed [65:0] rxe;
    logic signed [65:0] rye;
    logic signed [65:0] cxe;
    logic signed [65:0] cye;

    assign cxf = flip_dly ? (34'sd0 - cd_cx[NC]) : cd_cx[NC];
    assign cyf = flip_dly ? (34'sd0 - cd_cy[NC]) : cd_cy[NC];
    assign rxe = 66'($signed(rxy_dly[63:32]));
    assign rye = 66'($signed(rxy_dly[31:0]));
    assign cxe = 66'(cxf);
    assign cye = 66'(cyf);

    logic signed [65:0] pxc_reg;
    logic signed [65:0] pys_reg;
    logic signed [65:0] pxs_reg;
    logic signed [65:0] pyc_reg;
    logic signed [66:0] rsx_reg;
    logic signed [66:0] rsy_reg;
    logic signed [66:0] rrx;
    logic signed [66:0] rry;
    vtu_pkg::sat_t      rsatx;
    vtu_pkg::sat_t      rsaty;
    logic signed [31:0] rx_reg;
    logic signed [31:0] ry_reg;
    logic               rclip_reg;

    // round by 2^30 and clip
    always_comb
    begin
        rrx   = (rsx_reg + (67'sd1 <<< 29)) >>> 30;
        rry   = (rsy_reg + (67'sd1 <<< 29)) >>> 30;
        rsatx = vtu_pkg::sat32(rrx);
        rsaty = vtu_pkg::sat32(rry);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxc_reg   <= rxe * cxe;
            pys_reg   <= rye * cye;
            pxs_reg   <= rxe * cye;
            pyc_reg   <= rye * cxe;
            rsx_reg   <= 67'(pxc_reg) - 67'(pys_reg);
            rsy_reg   <= 67'(pxs_reg) + 67'(pyc_reg);
            rx_reg    <= rsatx.val;
            ry_reg    <= rsaty.val;
            rclip_reg <= rsatx.clip | rsaty.clip;
        end
    end

    logic [64:0] r_out;
    vtu_delay #(.WIDTH(65), .DEPTH(L - LEN_R)) u_r_dly (
        .clk  (clk),
        .en   (en),
        .din  ({rx_reg, ry_reg, rclip_reg}),
        .dout (r_out)
    );

    // ------------------------------------------------------------------
    // Scale and translate
    // ------------------------------------------------------------------
    logic signed [63:0] ae64;
    logic signed [63:0] be64;
    logic signed [63:0] spx_reg;
    logic signed [63:0] spy_reg;
    logic signed [32:0] tsx_reg;
    logic signed [32:0] tsy_reg;
    logic [2:0]         scmd_reg;

    assign ae64 = 64'(a_in);
    assign be64 = 64'(b_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spx_reg  <= xe64 * ae64;
            spy_reg  <= ye64 * be64;
            tsx_reg  <= 33'(x_in) + 33'(a_in);
            tsy_reg  <= 33'(y_in) + 33'(b_in);
            scmd_reg <= cmd_item.command;
        end
    end

    logic signed [66:0] srx;
    logic signed [66:0] sry;
    vtu_pkg::sat_t      ssx;
    vtu_pkg::sat_t      ssy;
    logic signed [31:0] stx_reg;
    logic signed [31:0] sty_reg;
    logic               stclip_reg;

    // rounded product for scale, plain sum for translate
    always_comb
    begin
        srx = (67'(spx_reg) + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sry = (67'(spy_reg) + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (scmd_reg == vtu_pkg::CMD_SCALE)
        begin
            ssx = vtu_pkg::sat32(srx);
            ssy = vtu_pkg::sat32(sry);
        end else begin
            ssx = vtu_pkg::sat32(67'(tsx_reg));
            ssy = vtu_pkg::sat32(67'(tsy_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stx_reg    <= ssx.val;
            sty_reg    <= ssy.val;
            stclip_reg <= ssx.clip | ssy.clip;
        end
    end

    logic [64:0] s_out;
    vtu_delay #(.WIDTH(65), .DEPTH(L - LEN_S)) u_s_dly (
        .clk  (clk),
        .en   (en),
        .din  ({stx_reg, sty_reg, stclip_reg}),
        .dout (s_out)
    );

    // command and point at the output stage
    logic [66:0] cmd_dly;
    vtu_delay #(.WIDTH(67), .DEPTH(L)) u_cmd_dly (
        .clk  (clk),
        .en   (en),
        .din  ({cmd_item.command, x_in, y_in}),
        .dout (cmd_dly)
    );

    // ------------------------------------------------------------------
    // Result select and output register
    // ------------------------------------------------------------------
    vtu_pkg::res_item_t out_next;
    vtu_pkg::res_item_t out_reg;

    always_comb
    begin
        out_next.out_x       = cmd_dly[63:32];
        out_next.out_y       = cmd_dly[31:0];
        out_next.length      = p_out[95:64];
        out_next.zero_length = 1'b0;
        out_next.saturated   = 1'b0;
        unique case (cmd_dly[66:64])
            vtu_pkg::CMD_ROTATE:
            begin
                out_next.out_x     = r_out[64:33];
                out_next.out_y     = r_out[32:1];
                out_next.saturated = r_out[0];
            end
            vtu_pkg::CMD_SCALE, vtu_pkg::CMD_TRANSLATE:
            begin
                out_next.out_x     = s_out[64:33];
                out_next.out_y     = s_out[32:1];
                out_next.saturated = s_out[0];
            end
            vtu_pkg::CMD_NORMALIZE:
            begin
                if (p_out[95:64] == 32'd0)
                begin
                    out_next.zero_length = 1'b1;
                end else begin
                    out_next.out_x = p_out[63:32];
                    out_next.out_y = p_out[31:0];
                end
            end
            default:
            begin
                out_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign res_item = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid && res_stall))
        else $error("input stalled without a held result");

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[L-1] && en) |=> res_valid)
        else $error("item lost in the last pipeline stage");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.zero_length) |-> (res_item.length == 32'd0 &&
        !res_item.saturated))
        else $error("zero-length flag with nonzero length or clip");

endmodule
`default_nettype wire
